// File: hdl/stq_pkg.sv
package stq_pkg;

	localparam int TimerSlotsDef = 16;
	localparam int DestQueuesDef = 16;
	localparam int MaxOut = 16;

	localparam int OpW = 2;
	localparam int SlotW = 4;
	localparam int DestW = 4;
	localparam int DataW = 8;
	localparam int TickW = 32;
	localparam int KindW = 2;

	localparam logic [OpW-1:0] OP_TICK = 2'd0;
	localparam logic [OpW-1:0] OP_ALLOC = 2'd1;
	localparam logic [OpW-1:0] OP_FREE = 2'd2;
	localparam logic [OpW-1:0] OP_ARM = 2'd3;

	localparam logic [KindW-1:0] KIND_EXPIRY = 2'd0;
	localparam logic [KindW-1:0] KIND_ALLOC = 2'd1;
	localparam logic [KindW-1:0] KIND_ACK = 2'd2;
	localparam logic [KindW-1:0] KIND_ERROR = 2'd3;

	localparam logic [1:0] SLOT_FREE = 2'd0;
	localparam logic [1:0] SLOT_ALLOC = 2'd1;
	localparam logic [1:0] SLOT_ACTIVE = 2'd2;

	// broadcast to every cell of the queue
	typedef struct packed {
		logic ins;
		logic pop;
		logic [TickW-1:0] dl;
		logic [DestW-1:0] dest;
		logic [DataW-1:0] data;
	} stq_ctl_t;

endpackage

// File: hdl/stq_if.sv
interface stq_req_if;
	logic valid;
	logic ready;
	logic [stq_pkg::OpW-1:0] op;
	logic [stq_pkg::SlotW-1:0] slot;
	logic [stq_pkg::DestW-1:0] dest;
	logic [stq_pkg::DataW-1:0] data;
	logic [stq_pkg::TickW-1:0] delay;
	modport source (output valid, op, slot, dest, data, delay, input ready);
	modport sink (input valid, op, slot, dest, data, delay, output ready);
endinterface

interface stq_rsp_if;
	logic valid;
	logic ready;
	logic [stq_pkg::KindW-1:0] kind;
	logic [stq_pkg::SlotW-1:0] slot_res;
	logic [stq_pkg::DestW-1:0] dest_res;
	logic [stq_pkg::DataW-1:0] data_res;
	logic last;
	logic [stq_pkg::TickW-1:0] tick_count;
	modport source (output valid, kind, slot_res, dest_res, data_res, last, tick_count,
		input ready);
	modport sink (input valid, kind, slot_res, dest_res, data_res, last, tick_count,
		output ready);
endinterface

// File: hdl/sorted_timer_queue.sv
// Timer pool with a deadline-sorted queue held in a row of cells, one cell per slot.
// Allocate, free and arm each give one result; an arm inserts into the row as it is
// accepted, every cell comparing its deadline with the new one in parallel.
// A tick first advances the counter and then gives its results in turn, each when the
// output register is free: either a single acknowledge, or one expiry per queued timer
// whose deadline has been reached (at most 16 per tick), the row shifting toward its
// head once per expiry. A new request is taken only when the previous one has finished
// and the output register is free.
module sorted_timer_queue #(
	parameter int TIMER_SLOTS = stq_pkg::TimerSlotsDef,
	parameter int DEST_QUEUES = stq_pkg::DestQueuesDef
) (
	input  logic clk,
	input  logic arst_n,
	stq_req_if.sink req,
	stq_rsp_if.source rsp
);

	localparam int SW = $clog2(TIMER_SLOTS);
	localparam int CW = $clog2(stq_pkg::MaxOut + 1);
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_TICK = 1'b1;

	logic state_q;
	logic [CW-1:0] n_q;
	logic [stq_pkg::TickW-1:0] tick_q;
	logic [1:0] status_q [TIMER_SLOTS];

	logic rsp_valid_q;
	logic [stq_pkg::KindW-1:0] kind_q;
	logic [stq_pkg::SlotW-1:0] slot_res_q;
	logic [stq_pkg::DestW-1:0] dest_res_q;
	logic [stq_pkg::DataW-1:0] data_res_q;
	logic last_q;
	logic [stq_pkg::TickW-1:0] tick_res_q;

	logic c_valid [TIMER_SLOTS];
	logic c_ge [TIMER_SLOTS];
	logic [stq_pkg::TickW-1:0] c_dl [TIMER_SLOTS];
	logic [SW-1:0] c_slot [TIMER_SLOTS];
	logic [stq_pkg::DestW-1:0] c_dest [TIMER_SLOTS];
	logic [stq_pkg::DataW-1:0] c_data [TIMER_SLOTS];

	stq_pkg::stq_ctl_t ctl;
	logic out_free, acc;
	logic [SW-1:0] slot_ix;
	logic slot_ok, dest_ok, slot_active;
	logic free_found;
	logic [SW-1:0] free_ix;
	logic head_exp, next_exp;
	logic emit, e_last;
	logic [stq_pkg::KindW-1:0] e_kind;
	logic [stq_pkg::SlotW-1:0] e_slot;
	logic [stq_pkg::DestW-1:0] e_dest;
	logic [stq_pkg::DataW-1:0] e_data;
	logic set_free, set_active, tick_go;

	assign out_free = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE) && out_free;
	assign acc = req.valid && req.ready;

	assign slot_ix = SW'(req.slot);
	assign slot_ok = 32'(req.slot) < TIMER_SLOTS;
	assign dest_ok = 32'(req.dest) < DEST_QUEUES;
	assign slot_active = status_q[slot_ix] == stq_pkg::SLOT_ACTIVE;

	always_comb begin
		free_found = 1'b0;
		free_ix = '0;
		for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
			if (status_q[i] == stq_pkg::SLOT_FREE) begin
				free_found = 1'b1;
				free_ix = SW'(i);
			end
		end
	end

	assign head_exp = c_valid[0] && (c_dl[0] <= tick_q) && (n_q < CW'(stq_pkg::MaxOut));
	assign next_exp = c_valid[1] && (c_dl[1] <= tick_q)
		&& ((n_q + CW'(1)) < CW'(stq_pkg::MaxOut));

	always_comb begin
		emit = 1'b0;
		e_kind = stq_pkg::KIND_ACK;
		e_slot = '0;
		e_dest = '0;
		e_data = '0;
		e_last = 1'b1;
		set_free = 1'b0;
		set_active = 1'b0;
		tick_go = 1'b0;
		ctl.ins = 1'b0;
		ctl.pop = 1'b0;
		ctl.dl = tick_q + req.delay;
		ctl.dest = req.dest;
		ctl.data = req.data;
		if (state_q == ST_TICK) begin
			if (out_free) begin
				emit = 1'b1;
				if (head_exp) begin
					e_kind = stq_pkg::KIND_EXPIRY;
					e_slot = stq_pkg::SlotW'(c_slot[0]);
					e_dest = c_dest[0];
					e_data = c_data[0];
					e_last = !next_exp;
					ctl.pop = 1'b1;
				end
			end
		end else if (acc) begin
			case (req.op)
				stq_pkg::OP_TICK: begin
					tick_go = 1'b1;
				end
				stq_pkg::OP_ALLOC: begin
					emit = 1'b1;
					if (free_found) begin
						e_kind = stq_pkg::KIND_ALLOC;
						e_slot = stq_pkg::SlotW'(free_ix);
					end else begin
						e_kind = stq_pkg::KIND_ERROR;
					end
				end
				stq_pkg::OP_FREE: begin
					emit = 1'b1;
					e_slot = req.slot;
					if (!slot_ok || slot_active) begin
						e_kind = stq_pkg::KIND_ERROR;
					end else begin
						set_free = 1'b1;
					end
				end
				default: begin
					emit = 1'b1;
					e_slot = req.slot;
					if (!slot_ok || slot_active || !dest_ok) begin
						e_kind = stq_pkg::KIND_ERROR;
					end else begin
						set_active = 1'b1;
						ctl.ins = 1'b1;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q <= '0;
			tick_q <= '0;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < TIMER_SLOTS; i++) begin
				status_q[i] <= stq_pkg::SLOT_FREE;
			end
		end else begin
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (tick_go) begin
				tick_q <= tick_q + 32'd1;
				n_q <= '0;
				state_q <= ST_TICK;
			end else if (state_q == ST_TICK && emit) begin
				n_q <= n_q + CW'(1);
				if (e_last) begin
					state_q <= ST_IDLE;
				end
			end
			if (ctl.pop) begin
				status_q[c_slot[0]] <= stq_pkg::SLOT_ALLOC;
			end
			if (set_free) begin
				status_q[slot_ix] <= stq_pkg::SLOT_FREE;
			end
			if (set_active) begin
				status_q[slot_ix] <= stq_pkg::SLOT_ACTIVE;
			end
			if (acc && req.op == stq_pkg::OP_ALLOC && free_found) begin
				status_q[free_ix] <= stq_pkg::SLOT_ALLOC;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q <= e_kind;
			slot_res_q <= e_slot;
			dest_res_q <= e_dest;
			data_res_q <= e_data;
			last_q <= e_last;
			tick_res_q <= tick_q;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.kind = kind_q;
	assign rsp.slot_res = slot_res_q;
	assign rsp.dest_res = dest_res_q;
	assign rsp.data_res = data_res_q;
	assign rsp.last = last_q;
	assign rsp.tick_count = tick_res_q;

	for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_cell
		logic l_valid, l_ge, r_valid;
		logic [stq_pkg::TickW-1:0] l_dl, r_dl;
		logic [SW-1:0] l_slot, r_slot;
		logic [stq_pkg::DestW-1:0] l_dest, r_dest;
		logic [stq_pkg::DataW-1:0] l_data, r_data;

		if (i == 0) begin : g_head
			assign l_valid = 1'b0;
			assign l_ge = 1'b0;
			assign l_dl = '0;
			assign l_slot = '0;
			assign l_dest = '0;
			assign l_data = '0;
		end else begin : g_mid
			assign l_valid = c_valid[i-1];
			assign l_ge = c_ge[i-1];
			assign l_dl = c_dl[i-1];
			assign l_slot = c_slot[i-1];
			assign l_dest = c_dest[i-1];
			assign l_data = c_data[i-1];
		end
		if (i == TIMER_SLOTS - 1) begin : g_tail
			assign r_valid = 1'b0;
			assign r_dl = '0;
			assign r_slot = '0;
			assign r_dest = '0;
			assign r_data = '0;
		end else begin : g_body
			assign r_valid = c_valid[i+1];
			assign r_dl = c_dl[i+1];
			assign r_slot = c_slot[i+1];
			assign r_dest = c_dest[i+1];
			assign r_data = c_data[i+1];
		end

		stq_cell #(.SW(SW)) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(ctl),
			.new_slot(slot_ix),
			.lft_valid(l_valid),
			.lft_ge(l_ge),
			.lft_dl(l_dl),
			.lft_slot(l_slot),
			.lft_dest(l_dest),
			.lft_data(l_data),
			.rgt_valid(r_valid),
			.rgt_dl(r_dl),
			.rgt_slot(r_slot),
			.rgt_dest(r_dest),
			.rgt_data(r_data),
			.valid(c_valid[i]),
			.ge(c_ge[i]),
			.dl(c_dl[i]),
			.slot(c_slot[i]),
			.dest(c_dest[i]),
			.data(c_data[i])
		);
	end

endmodule

// File: hdl/stq_cell.sv
module stq_cell #(
	parameter int SW = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  stq_pkg::stq_ctl_t ctl,
	input  logic [SW-1:0] new_slot,
	input  logic lft_valid,
	input  logic lft_ge,
	input  logic [stq_pkg::TickW-1:0] lft_dl,
	input  logic [SW-1:0] lft_slot,
	input  logic [stq_pkg::DestW-1:0] lft_dest,
	input  logic [stq_pkg::DataW-1:0] lft_data,
	input  logic rgt_valid,
	input  logic [stq_pkg::TickW-1:0] rgt_dl,
	input  logic [SW-1:0] rgt_slot,
	input  logic [stq_pkg::DestW-1:0] rgt_dest,
	input  logic [stq_pkg::DataW-1:0] rgt_data,
	output logic valid,
	output logic ge,
	output logic [stq_pkg::TickW-1:0] dl,
	output logic [SW-1:0] slot,
	output logic [stq_pkg::DestW-1:0] dest,
	output logic [stq_pkg::DataW-1:0] data
);

	logic valid_q;
	logic [stq_pkg::TickW-1:0] dl_q;
	logic [SW-1:0] slot_q;
	logic [stq_pkg::DestW-1:0] dest_q;
	logic [stq_pkg::DataW-1:0] data_q;

	// an empty cell counts as later than any new deadline
	assign ge = !valid_q || (dl_q >= ctl.dl);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.pop) begin
			valid_q <= rgt_valid;
		end else if (ctl.ins) begin
			if (lft_ge) begin
				valid_q <= lft_valid;
			end else if (ge) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			dl_q <= rgt_dl;
			slot_q <= rgt_slot;
			dest_q <= rgt_dest;
			data_q <= rgt_data;
		end else if (ctl.ins) begin
			if (lft_ge) begin
				dl_q <= lft_dl;
				slot_q <= lft_slot;
				dest_q <= lft_dest;
				data_q <= lft_data;
			end else if (ge) begin
				dl_q <= ctl.dl;
				slot_q <= new_slot;
				dest_q <= ctl.dest;
				data_q <= ctl.data;
			end
		end
	end

	assign valid = valid_q;
	assign dl = dl_q;
	assign slot = slot_q;
	assign dest = dest_q;
	assign data = data_q;

endmodule

// File: hdl/stq_checker.sv
module stq_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic [stq_pkg::OpW-1:0] req_op,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic [stq_pkg::KindW-1:0] rsp_kind,
	input logic [stq_pkg::DestW-1:0] rsp_dest_res,
	input logic [stq_pkg::DataW-1:0] rsp_data_res,
	input logic rsp_last,
	input logic [stq_pkg::TickW-1:0] rsp_tick_count
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
			&& $stable(rsp_last) && $stable(rsp_tick_count))
		else $error("stalled result changed");

	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_op != stq_pkg::OP_TICK |=> rsp_valid && rsp_last)
		else $error("non-tick request gave no single result");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_kind != stq_pkg::KIND_EXPIRY |-> rsp_last)
		else $error("non-expiry result not marked last");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_kind != stq_pkg::KIND_EXPIRY |-> rsp_dest_res == '0
			&& rsp_data_res == '0)
		else $error("non-expiry result carries timer payload");

endmodule

bind sorted_timer_queue stq_checker u_stq_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.req_op(req.op),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_kind(rsp.kind),
	.rsp_dest_res(rsp.dest_res),
	.rsp_data_res(rsp.data_res),
	.rsp_last(rsp.last),
	.rsp_tick_count(rsp.tick_count)
);

// File: dv/tb_sorted_timer_queue.sv
module tb_sorted_timer_queue;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int Slots = stq_pkg::TimerSlotsDef;
	localparam int Dests = stq_pkg::DestQueuesDef;
	localparam int RandItems = 340;

	typedef struct packed {
		logic [stq_pkg::OpW-1:0] op;
		logic [stq_pkg::SlotW-1:0] slot;
		logic [stq_pkg::DestW-1:0] dest;
		logic [stq_pkg::DataW-1:0] data;
		logic [stq_pkg::TickW-1:0] delay;
	} timer_req_t;

	typedef struct packed {
		logic [stq_pkg::KindW-1:0] kind;
		logic [stq_pkg::SlotW-1:0] slot;
		logic [stq_pkg::DestW-1:0] dest;
		logic [stq_pkg::DataW-1:0] data;
		logic last;
		logic [stq_pkg::TickW-1:0] ticks;
	} timer_evt_t;

	// directed row, kind and slot of the first result typed in where chk is set
	typedef struct packed {
		timer_req_t rq;
		logic chk;
		logic [stq_pkg::KindW-1:0] kind;
		logic [stq_pkg::SlotW-1:0] slot;
	} dir_row_t;

	logic clk;
	logic arst_n;
	stq_req_if req ();
	stq_rsp_if rsp ();

	sorted_timer_queue dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	// predicted timer state
	logic [stq_pkg::TickW-1:0] ticks_q;
	logic [stq_pkg::TickW-1:0] nearest_q;
	int qlen;
	logic [stq_pkg::SlotW-1:0] order_q [Slots];
	logic [stq_pkg::TickW-1:0] deadline_q [Slots];
	logic [1:0] status_q [Slots];
	logic [stq_pkg::DestW-1:0] dest_q [Slots];
	logic [stq_pkg::DataW-1:0] data_q [Slots];

	timer_evt_t pending_evts [$];
	int fails;
	int send_idle_pct;
	int recv_stall_pct;
	bit hold_req;
	int hold_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic timer_evt_t mk_evt(logic [stq_pkg::KindW-1:0] k,
		logic [stq_pkg::SlotW-1:0] s, logic [stq_pkg::DestW-1:0] d,
		logic [stq_pkg::DataW-1:0] v, logic l);
		timer_evt_t e;
		e.kind = k;
		e.slot = s;
		e.dest = d;
		e.data = v;
		e.last = l;
		e.ticks = ticks_q;
		return e;
	endfunction

	task automatic predict_timers(input timer_req_t r, output timer_evt_t first);
		int n;
		int i;
		int j;
		int s;
		logic [stq_pkg::TickW-1:0] dl;
		timer_evt_t e;
		n = 0;
		if (r.op == stq_pkg::OP_TICK) begin
			ticks_q = ticks_q + 1;
			if (nearest_q <= ticks_q) begin
				while (n < qlen && n < stq_pkg::MaxOut) begin
					s = order_q[n];
					if (deadline_q[s] > ticks_q) break;
					status_q[s] = stq_pkg::SLOT_ALLOC;
					e = mk_evt(stq_pkg::KIND_EXPIRY, stq_pkg::SlotW'(s), dest_q[s],
						data_q[s], 1'b0);
					if (n == 0) first = e;
					pending_evts.push_back(e);
					n++;
				end
				qlen -= n;
				for (j = 0; j < qlen; j++) order_q[j] = order_q[j + n];
				nearest_q = (qlen > 0) ? deadline_q[order_q[0]] : 32'hffff_ffff;
			end
			if (n == 0) begin
				first = mk_evt(stq_pkg::KIND_ACK, '0, '0, '0, 1'b1);
				pending_evts.push_back(first);
			end else begin
				pending_evts[pending_evts.size() - 1].last = 1'b1;
				if (n == 1) first.last = 1'b1;
			end
		end else if (r.op == stq_pkg::OP_ALLOC) begin
			first = mk_evt(stq_pkg::KIND_ERROR, '0, '0, '0, 1'b1);
			for (i = 0; i < Slots; i++) begin
				if (status_q[i] == stq_pkg::SLOT_FREE) begin
					status_q[i] = stq_pkg::SLOT_ALLOC;
					first = mk_evt(stq_pkg::KIND_ALLOC, stq_pkg::SlotW'(i), '0, '0, 1'b1);
					break;
				end
			end
			pending_evts.push_back(first);
		end else if (r.slot >= Slots || status_q[r.slot] == stq_pkg::SLOT_ACTIVE) begin
			first = mk_evt(stq_pkg::KIND_ERROR, r.slot, '0, '0, 1'b1);
			pending_evts.push_back(first);
		end else if (r.op == stq_pkg::OP_FREE) begin
			status_q[r.slot] = stq_pkg::SLOT_FREE;
			first = mk_evt(stq_pkg::KIND_ACK, r.slot, '0, '0, 1'b1);
			pending_evts.push_back(first);
		end else if (r.dest >= Dests) begin
			first = mk_evt(stq_pkg::KIND_ERROR, r.slot, '0, '0, 1'b1);
			pending_evts.push_back(first);
		end else begin
			s = r.slot;
			dest_q[s] = r.dest;
			data_q[s] = r.data;
			dl = ticks_q + r.delay;
			deadline_q[s] = dl;
			status_q[s] = stq_pkg::SLOT_ACTIVE;
			// new timer goes ahead of older ones with the same deadline
			for (i = 0; i < qlen; i++) if (deadline_q[order_q[i]] >= dl) break;
			if (qlen < Slots) begin
				for (j = qlen; j > i; j--) order_q[j] = order_q[j - 1];
				order_q[i] = r.slot;
				qlen++;
			end
			nearest_q = deadline_q[order_q[0]];
			first = mk_evt(stq_pkg::KIND_ACK, r.slot, '0, '0, 1'b1);
			pending_evts.push_back(first);
		end
	endtask

	task automatic send_beat(input timer_req_t r, output timer_evt_t first);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.op <= r.op;
		req.slot <= r.slot;
		req.dest <= r.dest;
		req.data <= r.data;
		req.delay <= r.delay;
		do @(posedge clk); while (!req.ready);
		predict_timers(r, first);
	endtask

	function automatic timer_req_t rand_req();
		timer_req_t r;
		int pick;
		int k;
		r.op = stq_pkg::OpW'($urandom_range(3));
		r.slot = stq_pkg::SlotW'($urandom_range(Slots - 1));
		r.dest = stq_pkg::DestW'($urandom_range(15));
		r.data = stq_pkg::DataW'($urandom_range(255));
		r.delay = $urandom;
		pick = $urandom_range(99);
		if (pick < 10) return r;
		if (pick < 45) r.op = stq_pkg::OP_TICK;
		else if (pick < 60) r.op = stq_pkg::OP_ALLOC;
		else if (pick < 70) r.op = stq_pkg::OP_FREE;
		else r.op = stq_pkg::OP_ARM;
		// mostly address a slot that is allocated
		if ($urandom_range(3) != 0) begin
			k = $urandom_range(Slots - 1);
			for (int i = 0; i < Slots; i++) begin
				if (status_q[(k + i) % Slots] == stq_pkg::SLOT_ALLOC) begin
					r.slot = stq_pkg::SlotW'((k + i) % Slots);
					break;
				end
			end
		end
		if ($urandom_range(59) != 0) r.delay = $urandom_range(6);
		return r;
	endfunction

	always @(posedge clk) begin
		if (hold_req && hold_left == 0) hold_left <= 200;
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		timer_evt_t act;
		timer_evt_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			act.kind = rsp.kind;
			act.slot = rsp.slot_res;
			act.dest = rsp.dest_res;
			act.data = rsp.data_res;
			act.last = rsp.last;
			act.ticks = rsp.tick_count;
			if (pending_evts.size() == 0) begin
				fails++;
				$display("%t unexpected beat: kind %0d slot %0d tick %0d", $realtime,
					act.kind, act.slot, act.ticks);
			end else begin
				want = pending_evts.pop_front();
				if (act !== want) begin
					fails++;
					$display("%t mismatch exp kind %0d slot %0d dest %0d data %0d last %0d tick %0d",
						$realtime, want.kind, want.slot, want.dest, want.data, want.last,
						want.ticks);
					$display("%t          act kind %0d slot %0d dest %0d data %0d last %0d tick %0d",
						$realtime, act.kind, act.slot, act.dest, act.data, act.last, act.ticks);
				end
			end
		end
	end

	initial begin
		dir_row_t dir [$];
		timer_evt_t first;
		int ph;
		int n;
		int guard;
		int idle_tab [4];
		int stall_tab [4];
		idle_tab = '{0, 75, 0, 21};
		stall_tab = '{0, 0, 75, 21};
		fails = 0;
		hold_req = 1'b0;
		hold_left = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.op = stq_pkg::OP_TICK;
		req.slot = '0;
		req.dest = '0;
		req.data = '0;
		req.delay = '0;
		rsp.ready = 1'b0;
		ticks_q = '0;
		nearest_q = 32'hffff_ffff;
		qlen = 0;
		for (int i = 0; i < Slots; i++) begin
			order_q[i] = '0;
			deadline_q[i] = '0;
			status_q[i] = stq_pkg::SLOT_FREE;
			dest_q[i] = '0;
			data_q[i] = '0;
		end

		dir.push_back('{'{stq_pkg::OP_TICK, 4'd0, 4'd0, 8'd0, 32'd0}, 1'b1,
			stq_pkg::KIND_ACK, 4'd0});
		dir.push_back('{'{stq_pkg::OP_ALLOC, 4'd9, 4'd0, 8'd0, 32'd0}, 1'b1,
			stq_pkg::KIND_ALLOC, 4'd0});
		dir.push_back('{'{stq_pkg::OP_ALLOC, 4'd0, 4'd0, 8'd0, 32'd0}, 1'b1,
			stq_pkg::KIND_ALLOC, 4'd1});
		dir.push_back('{'{stq_pkg::OP_FREE, 4'd1, 4'd0, 8'd0, 32'd0}, 1'b1,
			stq_pkg::KIND_ACK, 4'd1});
		// freeing a free slot is acknowledged
		dir.push_back('{'{stq_pkg::OP_FREE, 4'd1, 4'd0, 8'd0, 32'd0}, 1'b1,
			stq_pkg::KIND_ACK, 4'd1});
		dir.push_back('{'{stq_pkg::OP_ARM, 4'd0, 4'd15, 8'd255, 32'd0}, 1'b1,
			stq_pkg::KIND_ACK, 4'd0});
		// active slot rejected by arm and free
		dir.push_back('{'{stq_pkg::OP_ARM, 4'd0, 4'd3, 8'd3, 32'd5}, 1'b1,
			stq_pkg::KIND_ERROR, 4'd0});
		dir.push_back('{'{stq_pkg::OP_FREE, 4'd0, 4'd0, 8'd0, 32'd0}, 1'b1,
			stq_pkg::KIND_ERROR, 4'd0});
		// arming a free slot, then equal deadlines
		dir.push_back('{'{stq_pkg::OP_ARM, 4'd2, 4'd0, 8'd0, 32'd1}, 1'b1,
			stq_pkg::KIND_ACK, 4'd2});
		dir.push_back('{'{stq_pkg::OP_ARM, 4'd3, 4'd7, 8'h5a, 32'd1}, 1'b1,
			stq_pkg::KIND_ACK, 4'd3});
		dir.push_back('{'{stq_pkg::OP_TICK, 4'd0, 4'd0, 8'd0, 32'd0}, 1'b0,
			stq_pkg::KIND_EXPIRY, 4'd0});
		// deadline wraps around behind the counter
		dir.push_back('{'{stq_pkg::OP_ARM, 4'd15, 4'd9, 8'ha5, 32'hffff_ffff}, 1'b1,
			stq_pkg::KIND_ACK, 4'd15});
		dir.push_back('{'{stq_pkg::OP_ARM, 4'd4, 4'd1, 8'd1, 32'h8000_0000}, 1'b0,
			stq_pkg::KIND_ACK, 4'd4});
		dir.push_back('{'{stq_pkg::OP_TICK, 4'd0, 4'd0, 8'd0, 32'd0}, 1'b0,
			stq_pkg::KIND_EXPIRY, 4'd0});
		dir.push_back('{'{stq_pkg::OP_TICK, 4'd0, 4'd0, 8'd0, 32'd0}, 1'b1,
			stq_pkg::KIND_ACK, 4'd0});
		for (int i = 0; i < 16; i++)
			dir.push_back('{'{stq_pkg::OP_ALLOC, 4'd0, 4'd0, 8'd0, 32'd0}, 1'b0,
				stq_pkg::KIND_ALLOC, 4'd0});

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir[i]) begin
			send_beat(dir[i].rq, first);
			if (dir[i].chk && (first.kind !== dir[i].kind || first.slot !== dir[i].slot)) begin
				fails++;
				$display("%t row %0d exp kind %0d slot %0d act kind %0d slot %0d", $realtime,
					i, dir[i].kind, dir[i].slot, first.kind, first.slot);
			end
		end
		// release most slots again
		for (int i = 0; i < Slots; i++) if (i % 3 != 0)
			send_beat('{stq_pkg::OP_FREE, 4'(i), 4'd0, 8'd0, 32'd0}, first);

		for (ph = 0; ph < 4; ph++) begin
			req.valid <= 1'b0;
			// sender waits for the block to drain
			guard = 0;
			while (pending_evts.size() != 0 && guard < 100000) begin
				@(posedge clk);
				guard++;
			end
			send_idle_pct = idle_tab[ph];
			recv_stall_pct = stall_tab[ph];
			if (ph == 2) begin
				// long receiver hold starts before the sender goes on
				hold_req = 1'b1;
				wait (hold_left > 0);
				hold_req = 1'b0;
			end
			for (n = 0; n < RandItems / 4; n++) begin
				send_beat(rand_req(), first);
			end
		end
		req.valid <= 1'b0;
		recv_stall_pct = 0;
		while (pending_evts.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (fails == 0 && pending_evts.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
